// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Self-contained; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/kti_pkg.sv -----
// Package for the keyed table: item structs, command and status codes,
// controller states and the controller/datapath control structs. No dependencies.
`default_nettype none
package kti_pkg;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   localparam logic [2:0] ST_ADDED     = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_DELETED   = 3'd3;
   localparam logic [2:0] ST_NOTFOUND  = 3'd4;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] entry_key;
      logic [63:0]        entry_payload;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] entries_used;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [63:0] payload;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_COMPARE,
      S_INSERT,
      S_SHIFT_READ,
      S_SHIFT_WRITE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_en;
      logic rd_next;
      logic inc_idx;
      logic wr_ins;
      logic wr_shift;
      logic dec_cnt;
   } dp_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic key_match;
      logic next_in_range;
   } dp_sts_type;

endpackage
`default_nettype wire

// ----- rtl/kti_ctrl.sv -----
// Controller state machine for the keyed table: sequences lookup, append and
// compaction. Uses kti_pkg; drives kti_dpath through dp_ctl_type.
`default_nettype none
module kti_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                req_cmd,
   input  wire kti_pkg::dp_sts_type sts,
   output kti_pkg::dp_ctl_type      ctl,
   output logic                     busy,
   output logic                     rsp_valid,
   output logic [2:0]               rsp_status
);

   kti_pkg::state_type state_ff, state_in;
   logic [2:0]         status_ff, status_in;
   logic               op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kti_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      status_ff <= status_in;
      op_ff     <= op_in;
   end

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      op_in     = op_ff;
      ctl       = '0;
      case (state_ff)
         kti_pkg::S_IDLE: begin
            if (start) begin
               op_in    = req_cmd;
               ctl.load = 1'b1;
               if (req_cmd == kti_pkg::CMD_INSERT && sts.full) begin
                  status_in = kti_pkg::ST_FULL;
                  state_in  = kti_pkg::S_RESP;
               end else if (sts.empty) begin
                  if (req_cmd == kti_pkg::CMD_INSERT) begin
                     state_in = kti_pkg::S_INSERT;
                  end else begin
                     status_in = kti_pkg::ST_NOTFOUND;
                     state_in  = kti_pkg::S_RESP;
                  end
               end else begin
                  state_in = kti_pkg::S_LOOKUP;
               end
            end
         end
         kti_pkg::S_LOOKUP: begin
            ctl.rd_en = 1'b1;
            state_in  = kti_pkg::S_COMPARE;
         end
         kti_pkg::S_COMPARE: begin
            if (sts.key_match) begin
               if (op_ff == kti_pkg::CMD_INSERT) begin
                  status_in = kti_pkg::ST_DUPLICATE;
                  state_in  = kti_pkg::S_RESP;
               end else begin
                  state_in = kti_pkg::S_SHIFT_READ;
               end
            end else begin
               ctl.inc_idx = 1'b1;
               if (sts.next_in_range) begin
                  state_in = kti_pkg::S_LOOKUP;
               end else if (op_ff == kti_pkg::CMD_INSERT) begin
                  state_in = kti_pkg::S_INSERT;
               end else begin
                  status_in = kti_pkg::ST_NOTFOUND;
                  state_in  = kti_pkg::S_RESP;
               end
            end
         end
         kti_pkg::S_INSERT: begin
            ctl.wr_ins = 1'b1;
            status_in  = kti_pkg::ST_ADDED;
            state_in   = kti_pkg::S_RESP;
         end
         kti_pkg::S_SHIFT_READ: begin
            if (sts.next_in_range) begin
               ctl.rd_en   = 1'b1;
               ctl.rd_next = 1'b1;
               state_in    = kti_pkg::S_SHIFT_WRITE;
            end else begin
               ctl.dec_cnt = 1'b1;
               status_in   = kti_pkg::ST_DELETED;
               state_in    = kti_pkg::S_RESP;
            end
         end
         kti_pkg::S_SHIFT_WRITE: begin
            ctl.wr_shift = 1'b1;
            ctl.inc_idx  = 1'b1;
            state_in     = kti_pkg::S_SHIFT_READ;
         end
         kti_pkg::S_RESP: begin
            state_in = kti_pkg::S_IDLE;
         end
         default: begin
            state_in = kti_pkg::S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != kti_pkg::S_IDLE);
   assign rsp_valid  = (state_ff == kti_pkg::S_RESP);
   assign rsp_status = status_ff;

endmodule
`default_nettype wire

// ----- rtl/kti_dpath.sv -----
// Datapath for the keyed table: entry memory, scan index, entry count and
// key compare. Uses kti_pkg; controlled by kti_ctrl.
`default_nettype none
module kti_dpath #(
   parameter int DEPTH = 128
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire kti_pkg::req_type    req_item,
   input  wire kti_pkg::dp_ctl_type ctl,
   output kti_pkg::dp_sts_type      sts,
   output logic [7:0]               entries_used
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   kti_pkg::entry_type mem [DEPTH];
   kti_pkg::entry_type rd_ff;
   kti_pkg::entry_type wr_data;

   logic [31:0]   key_ff;
   logic [63:0]   payload_ff;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_plus;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   logic [CW+7:0] count_ext;

   assign idx_plus = idx_ff + CW'(1);
   assign rd_addr  = ctl.rd_next ? idx_plus[AW-1:0] : idx_ff[AW-1:0];
   assign wr_en    = ctl.wr_ins | ctl.wr_shift;
   assign wr_addr  = ctl.wr_ins ? count_ff[AW-1:0] : idx_ff[AW-1:0];

   always_comb begin
      if (ctl.wr_ins) begin
         wr_data.key     = key_ff;
         wr_data.payload = payload_ff;
      end else begin
         wr_data = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (ctl.load) begin
         idx_in = '0;
      end else if (ctl.inc_idx) begin
         idx_in = idx_plus;
      end
      count_in = count_ff;
      if (ctl.wr_ins) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.dec_cnt) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
      if (ctl.load) begin
         key_ff     <= req_item.entry_key;
         payload_ff <= req_item.entry_payload;
      end
   end

   assign sts.full          = (count_ff == CW'(DEPTH));
   assign sts.empty         = (count_ff == '0);
   assign sts.key_match     = (rd_ff.key == key_ff);
   assign sts.next_in_range = (idx_plus < count_ff);

   assign count_ext    = {8'b0, count_ff};
   assign entries_used = count_ext[7:0];

endmodule
`default_nettype wire

// ----- rtl/keyed_table_insert_delete.sv -----
// Keyed table, insert and delete by unique key. The result is accepted the cycle after the
// item for a full-table insert or a delete on an empty table; otherwise the scan (lookup,
// compare) and the compaction (shift read, shift write) step through one entry at a time.
// One item at a time; busy falls the cycle after the result strobe. The receiver cannot
// stall. Synchronous reset empties the table (count to zero); memory contents are not
// cleared.
`default_nettype none
module keyed_table_insert_delete #(
   parameter int DEPTH = 128
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire kti_pkg::req_type req_item,
   output logic                  rsp_valid,
   output kti_pkg::rsp_type      rsp_item
);

   kti_pkg::dp_ctl_type ctl;
   kti_pkg::dp_sts_type sts;
   logic [2:0]          status;
   logic [7:0]          used;

   kti_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_cmd    (req_item.cmd),
      .sts        (sts),
      .ctl        (ctl),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_status (status)
   );

   kti_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_item     (req_item),
      .ctl          (ctl),
      .sts          (sts),
      .entries_used (used)
   );

   assign rsp_item.status       = status;
   assign rsp_item.entries_used = used;

endmodule
`default_nettype wire

// ----- rtl/kti_checker.sv -----
// Port-level checks for keyed_table_insert_delete, bound to the top level.
// Uses kti_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module kti_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire kti_pkg::rsp_type rsp_item
);

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, start && !busy, busy)
   `ASSERT_IMPL(a_rsp_while_busy, clock, reset, rsp_valid, busy)
   `ASSERT_NEXT(a_idle_after_rsp, clock, reset, rsp_valid, !busy && !rsp_valid)
   `ASSERT_IMPL(a_status_code, clock, reset, rsp_valid, rsp_item.status <= kti_pkg::ST_NOTFOUND)

endmodule

bind keyed_table_insert_delete kti_checker u_kti_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for keyed_table_insert_delete: a queue-fed driver, a result monitor
// and a behavioral table model that predicts status and entry count for every item.
// Depends on kti_pkg and the keyed_table_insert_delete RTL.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH  = 128;
   localparam int POOL_SIZE    = 170;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 300;

   typedef enum int { IDLE_NONE, IDLE_HALF, IDLE_QUARTER } idle_mode_type;

   typedef struct {
      kti_pkg::req_type item;
      int unsigned      gap;
      bit               wait_empty;
   } pending_item_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   kti_pkg::req_type req_item = '0;
   logic             busy;
   logic             rsp_valid;
   kti_pkg::rsp_type rsp_item;

   pending_item_type pending_items[$];
   kti_pkg::rsp_type expected_rsps[$];

   logic [31:0] model_keys[TABLE_DEPTH];
   logic [63:0] model_payloads[TABLE_DEPTH];
   int          model_count = 0;

   logic [31:0] key_pool[POOL_SIZE];
   int          mismatches = 0;
   int          quiet_cycles = 0;
   int          queued = 0;
   idle_mode_type idle_mode = IDLE_NONE;

   keyed_table_insert_delete #(.DEPTH(TABLE_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #10 clock = ~clock;

   // Apply one item to the table model and return the expected result.
   function automatic kti_pkg::rsp_type table_apply(kti_pkg::req_type it);
      kti_pkg::rsp_type r;
      int               hit;
      hit = -1;
      for (int i = 0; i < model_count; i++) begin
         if (hit < 0 && model_keys[i] == it.entry_key) hit = i;
      end
      if (it.cmd == kti_pkg::CMD_INSERT) begin
         if (model_count >= TABLE_DEPTH) begin
            r.status = kti_pkg::ST_FULL;
         end else if (hit >= 0) begin
            r.status = kti_pkg::ST_DUPLICATE;
         end else begin
            model_keys[model_count]     = it.entry_key;
            model_payloads[model_count] = it.entry_payload;
            model_count++;
            r.status = kti_pkg::ST_ADDED;
         end
      end else if (hit < 0) begin
         r.status = kti_pkg::ST_NOTFOUND;
      end else begin
         for (int i = hit; i + 1 < model_count; i++) begin
            model_keys[i]     = model_keys[i + 1];
            model_payloads[i] = model_payloads[i + 1];
         end
         model_count--;
         r.status = kti_pkg::ST_DELETED;
      end
      r.entries_used = 8'(model_count);
      return r;
   endfunction

   function automatic logic [63:0] rand_payload();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [31:0] rand_key();
      if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   task automatic queue_item(logic cmd, logic [31:0] key, logic [63:0] payload,
                             bit wait_empty = 1'b0);
      pending_item_type p;
      int unsigned      pct;
      // idling mode rotates every 60 items
      case ((queued / 60) % 4)
         1: idle_mode = IDLE_HALF;
         3: idle_mode = IDLE_QUARTER;
         default: idle_mode = IDLE_NONE;
      endcase
      pct = (idle_mode == IDLE_HALF) ? 50 : (idle_mode == IDLE_QUARTER) ? 25 : 0;
      p.item.cmd           = cmd;
      p.item.entry_key     = key;
      p.item.entry_payload = payload;
      p.gap        = ($urandom_range(0, 99) < pct) ? $urandom_range(1, 6) : 0;
      p.wait_empty = wait_empty || ($urandom_range(0, 99) == 0);
      pending_items.push_back(p);
      queued++;
   endtask

   // driver
   always @(posedge clock) begin : drive
      logic             next_start;
      kti_pkg::req_type next_item;
      next_start = start;
      next_item  = req_item;
      if (reset) begin
         next_start = 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(table_apply(req_item));
            next_start = 1'b0;
         end
         if (!next_start && pending_items.size() > 0) begin
            if (pending_items[0].wait_empty && expected_rsps.size() > 0) begin
               next_start = 1'b0;
            end else if (pending_items[0].gap > 0) begin
               pending_items[0].gap--;
            end else begin
               next_item  = pending_items[0].item;
               next_start = 1'b1;
               void'(pending_items.pop_front());
            end
         end
      end
      start    <= next_start;
      req_item <= next_item;
   end

   // monitor
   always @(posedge clock) begin : monitor
      kti_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result: status %0d count %0d",
                        rsp_item.status, rsp_item.entries_used);
            mismatches++;
         end else begin
            want = expected_rsps.pop_front();
            if (want.status !== rsp_item.status ||
                want.entries_used !== rsp_item.entries_used) begin
               if (mismatches < 10)
                  $display("mismatch: status exp %0d got %0d, count exp %0d got %0d",
                           want.status, rsp_item.status,
                           want.entries_used, rsp_item.entries_used);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no progress for %0d cycles", STALL_LIMIT);
         $display("tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      // directed: empty table, key extremes, sign-bit aliasing, duplicates,
      // deletes at head, middle and tail
      queue_item(kti_pkg::CMD_DELETE, 32'h0000_0000, rand_payload());
      queue_item(kti_pkg::CMD_INSERT, 32'h8000_0000, 64'h0);
      queue_item(kti_pkg::CMD_INSERT, 32'h7FFF_FFFF, '1);
      queue_item(kti_pkg::CMD_INSERT, 32'h0000_0000, 64'h5555_5555_5555_5555);
      queue_item(kti_pkg::CMD_INSERT, 32'hFFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA);
      queue_item(kti_pkg::CMD_INSERT, 32'h7FFF_FFFF, rand_payload());
      queue_item(kti_pkg::CMD_INSERT, 32'h8000_0000, rand_payload());
      queue_item(kti_pkg::CMD_DELETE, 32'h1234_5678, rand_payload());
      queue_item(kti_pkg::CMD_DELETE, 32'h8000_0000, '1);
      queue_item(kti_pkg::CMD_DELETE, 32'hFFFF_FFFF, 64'h0);
      queue_item(kti_pkg::CMD_INSERT, 32'h0000_0001, rand_payload());
      queue_item(kti_pkg::CMD_DELETE, 32'h0000_0000, rand_payload());
      queue_item(kti_pkg::CMD_DELETE, 32'h7FFF_FFFF, rand_payload());
      queue_item(kti_pkg::CMD_DELETE, 32'h0000_0001, rand_payload());
      queue_item(kti_pkg::CMD_DELETE, 32'h0000_0001, rand_payload());
      queue_item(kti_pkg::CMD_INSERT, 32'h0000_0005, rand_payload());
      queue_item(kti_pkg::CMD_INSERT, 32'h8000_0005, rand_payload());
      queue_item(kti_pkg::CMD_INSERT, 32'h8000_0005, rand_payload());
      queue_item(kti_pkg::CMD_DELETE, 32'h8000_0005, '1);
      queue_item(kti_pkg::CMD_DELETE, 32'h0000_0005, rand_payload());
      queue_item(kti_pkg::CMD_INSERT, 32'hFFFF_FFFE, '1);
      queue_item(kti_pkg::CMD_DELETE, 32'hFFFF_FFFE, '1);

      // random mix, insert heavy
      for (int i = 0; i < 120; i++)
         queue_item(($urandom_range(0, 99) < 70) ? kti_pkg::CMD_INSERT : kti_pkg::CMD_DELETE,
                    rand_key(), rand_payload());
      // fill to capacity, then hit it with new and duplicate keys
      for (int i = 0; i < POOL_SIZE; i++)
         queue_item(kti_pkg::CMD_INSERT, key_pool[i], rand_payload(), i == 0);
      for (int i = 0; i < 30; i++)
         queue_item(kti_pkg::CMD_INSERT, rand_key(), rand_payload());
      // random mix, delete heavy
      for (int i = 0; i < 130; i++)
         queue_item(($urandom_range(0, 99) < 40) ? kti_pkg::CMD_INSERT : kti_pkg::CMD_DELETE,
                    rand_key(), rand_payload());
      // delete every pool key, then a delete-heavy random mix
      for (int i = 0; i < POOL_SIZE; i++)
         queue_item(kti_pkg::CMD_DELETE, key_pool[i], rand_payload(), i == 0);
      for (int i = 0; i < 10; i++)
         queue_item(($urandom_range(0, 99) < 30) ? kti_pkg::CMD_INSERT : kti_pkg::CMD_DELETE,
                    rand_key(), rand_payload());

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (pending_items.size() == 0 && !start && expected_rsps.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $display("%0d results never arrived", expected_rsps.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/kti_pkg.sv
rtl/kti_ctrl.sv
rtl/kti_dpath.sv
rtl/keyed_table_insert_delete.sv
rtl/kti_checker.sv
tb/tb.sv
